>>> src/lpfp_pkg.sv
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared constants, types and helpers for the LED pixel frame packetizer.
// ----------------------------------------------------------------------------
package lpfp_pkg;

  localparam int MAX_PIXELS = 497;
  localparam int COL_W      = 13;
  localparam int CHUNK_W    = 9;
  localparam int MAC_W      = 48;
  localparam int MAC_BYTES  = 6;
  localparam int GAMMA_DEPTH = 256;

  // Byte positions inside a frame
  localparam logic [4:0] IDX_DEST_MAC = 5'd0;
  localparam logic [4:0] IDX_SRC_MAC  = 5'd6;
  localparam logic [4:0] IDX_TYPE     = 5'd12;
  localparam logic [4:0] IDX_ROW_HI   = 5'd13;
  localparam logic [4:0] IDX_ROW_LO   = 5'd14;
  localparam logic [4:0] IDX_COL_HI   = 5'd15;
  localparam logic [4:0] IDX_COL_LO   = 5'd16;
  localparam logic [4:0] IDX_CNT_HI   = 5'd17;
  localparam logic [4:0] IDX_CNT_LO   = 5'd18;
  localparam logic [4:0] IDX_TRAIL_HI = 5'd19;
  localparam logic [4:0] IDX_TRAIL_LO = 5'd20;
  localparam logic [4:0] IDX_PIXEL    = 5'd21;
  localparam logic [4:0] IDX_LAST     = 5'd23;

  localparam logic [7:0] TRAIL_HI_BYTE = 8'h08;
  localparam logic [7:0] TRAIL_LO_BYTE = 8'h00;

  // Configuration register indexes
  localparam logic [2:0] REG_PANEL_WIDTH  = 3'd0;
  localparam logic [2:0] REG_PANEL_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BYTE_ORDER   = 3'd2;
  localparam logic [2:0] REG_DEST_MAC     = 3'd3;
  localparam logic [2:0] REG_SRC_MAC      = 3'd4;
  localparam logic [2:0] REG_PACKET_TYPE  = 3'd5;

  // Color orders
  localparam logic [2:0] ORDER_BGR = 3'd0;
  localparam logic [2:0] ORDER_RGB = 3'd1;
  localparam logic [2:0] ORDER_GRB = 3'd2;
  localparam logic [2:0] ORDER_GBR = 3'd3;
  localparam logic [2:0] ORDER_RBG = 3'd4;
  localparam logic [2:0] ORDER_BRG = 3'd5;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TABLE = 1'b1;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } channel_t;

  // One request held while its bytes go out
  typedef struct packed {
    logic               req_type;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         tbl_index;
    logic [7:0]         tbl_value;
    logic [COL_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [CHUNK_W-1:0] cnt;
    logic               pend;
    logic               fend;
  } item_t;

  // Which raw channel goes out at byte position pos (0..2) of a pixel
  function automatic channel_t channel_sel(logic [2:0] order, logic [1:0] pos);
    channel_t ch;
    ch = CH_RED;
    case (order)
      ORDER_BGR: ch = (pos == 2'd0) ? CH_BLUE  : (pos == 2'd1) ? CH_GREEN : CH_RED;
      ORDER_GRB: ch = (pos == 2'd0) ? CH_GREEN : (pos == 2'd1) ? CH_RED   : CH_BLUE;
      ORDER_GBR: ch = (pos == 2'd0) ? CH_GREEN : (pos == 2'd1) ? CH_BLUE  : CH_RED;
      ORDER_RBG: ch = (pos == 2'd0) ? CH_RED   : (pos == 2'd1) ? CH_BLUE  : CH_GREEN;
      ORDER_BRG: ch = (pos == 2'd0) ? CH_BLUE  : (pos == 2'd1) ? CH_RED   : CH_GREEN;
      default:   ch = (pos == 2'd0) ? CH_RED   : (pos == 2'd1) ? CH_GREEN : CH_BLUE;
    endcase
    return ch;
  endfunction

endpackage

>>> src/led_pixel_frame_packetizer.sv
// ----------------------------------------------------------------------------
// led_pixel_frame_packetizer
// Gamma-corrects raster pixels and packs them into Ethernet frames per row chunk.
// ----------------------------------------------------------------------------
// A pixel request yields three bytes, and the first pixel of a chunk adds its
// 21-byte header. Output runs at one byte per cycle unless the sink stalls, and
// the next request is taken as the last byte of the current one is registered.
// The gamma table is a single-port RAM read once per color byte. Gamma entries
// must be written before any pixel that looks them up.
module led_pixel_frame_packetizer (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  // requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pixel_red, pixel_green, pixel_blue,
                                      // table_index, table_value
  input  logic        s_axis_tuser,   // req_type
  // frame bytes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // data_byte
  output logic        m_axis_tlast,   // packet_end
  output logic [1:0]  m_axis_tuser    // frame_end, run_last
);
  import lpfp_pkg::*;

  // Configuration registers
  logic [COL_W-1:0] panel_width;
  logic [COL_W-1:0] panel_height;
  logic [2:0]       byte_order;
  logic [MAC_W-1:0] dest_mac;
  logic [MAC_W-1:0] src_mac;
  logic [7:0]       pixel_packet_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width       <= COL_W'(128);
      panel_height      <= COL_W'(64);
      byte_order        <= ORDER_RGB;
      dest_mac          <= '0;
      src_mac           <= '0;
      pixel_packet_type <= 8'd85;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PANEL_WIDTH:  panel_width       <= cfg_data[COL_W-1:0];
        REG_PANEL_HEIGHT: panel_height      <= cfg_data[COL_W-1:0];
        REG_BYTE_ORDER:   byte_order        <= cfg_data[2:0];
        REG_DEST_MAC:     dest_mac          <= cfg_data;
        REG_SRC_MAC:      src_mac           <= cfg_data;
        REG_PACKET_TYPE:  pixel_packet_type <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [COL_W-1:0] eff_w;
  logic [COL_W-1:0] eff_h;
  assign eff_w = (panel_width  == '0) ? COL_W'(1) : panel_width;
  assign eff_h = (panel_height == '0) ? COL_W'(1) : panel_height;

  // Raster position
  logic [COL_W-1:0]   column_pos;
  logic [COL_W-1:0]   row_pos;
  logic [CHUNK_W-1:0] chunk_left;

  // Held request and byte sequencer
  item_t       item;
  item_t       item_next;
  logic        item_valid;
  logic [4:0]  idx;

  // Output stage
  logic        out_valid;
  logic        out_color;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_pend;
  logic        out_fend;

  logic        load;
  logic        advance;
  logic        item_done;
  logic        tbl_write;

  assign tbl_write = item_valid && (item.req_type == REQ_TABLE);
  assign advance   = item_valid && (item.req_type == REQ_PIXEL) &&
                     (!out_valid || m_axis_tready);
  assign item_done = tbl_write || (advance && idx == IDX_LAST);
  assign s_axis_tready = !item_valid || item_done;
  assign load = s_axis_tvalid && s_axis_tready;

  // Position update for an arriving pixel, done once at load
  logic               start;
  logic               col_wrap;
  logic [COL_W-1:0]   c0;
  logic [COL_W-1:0]   r0a;
  logic [COL_W-1:0]   r0;
  logic [COL_W-1:0]   cnt_full;
  logic [CHUNK_W-1:0] cnt;
  logic [CHUNK_W-1:0] cl1;
  logic [COL_W-1:0]   c1;
  logic [COL_W-1:0]   r1;
  logic               pend;
  logic               row_end;
  logic               fend;
  logic [COL_W-1:0]   column_pos_next;
  logic [COL_W-1:0]   row_pos_next;

  always_comb begin
    start    = (chunk_left == '0);
    col_wrap = start && (column_pos >= eff_w);
    c0       = col_wrap ? '0 : column_pos;
    r0a      = col_wrap ? row_pos + COL_W'(1) : row_pos;
    r0       = (start && r0a >= eff_h) ? '0 : r0a;
    cnt_full = eff_w - c0;
    cnt      = (cnt_full > COL_W'(MAX_PIXELS)) ? CHUNK_W'(MAX_PIXELS)
                                               : cnt_full[CHUNK_W-1:0];
    cl1      = (start ? cnt : chunk_left) - CHUNK_W'(1);
    c1       = c0 + COL_W'(1);
    r1       = r0 + COL_W'(1);
    pend     = (cl1 == '0);
    row_end  = pend && (c1 >= eff_w);
    fend     = row_end && (r1 >= eff_h);
    column_pos_next = row_end ? '0 : c1;
    row_pos_next    = fend ? '0 : (row_end ? r1 : r0);

    item_next.req_type  = s_axis_tuser;
    item_next.red       = s_axis_tdata[7:0];
    item_next.green     = s_axis_tdata[15:8];
    item_next.blue      = s_axis_tdata[23:16];
    item_next.tbl_index = s_axis_tdata[31:24];
    item_next.tbl_value = s_axis_tdata[39:32];
    item_next.row       = r0;
    item_next.col       = c0;
    item_next.cnt       = cnt;
    item_next.pend      = pend;
    item_next.fend      = fend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      column_pos <= '0;
      row_pos    <= '0;
      chunk_left <= '0;
      idx        <= '0;
    end else begin
      if (load) begin
        item_valid <= 1'b1;
        idx        <= start ? IDX_DEST_MAC : IDX_PIXEL;
        if (s_axis_tuser == REQ_PIXEL) begin
          column_pos <= column_pos_next;
          row_pos    <= row_pos_next;
          chunk_left <= cl1;
        end
      end else if (item_done) begin
        item_valid <= 1'b0;
      end else if (advance) begin
        idx <= idx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

  // Header byte for the current position
  logic [MAC_BYTES-1:0][7:0] dest_bytes;
  logic [MAC_BYTES-1:0][7:0] src_bytes;
  logic [2:0]                mac_sel;
  logic [7:0]                hdr_byte;
  logic                      is_color;

  assign dest_bytes = dest_mac;
  assign src_bytes  = src_mac;
  assign is_color   = (idx >= IDX_PIXEL);

  always_comb begin
    mac_sel  = '0;
    hdr_byte = '0;
    if (idx < IDX_SRC_MAC) begin
      mac_sel  = 3'(MAC_BYTES - 1) - idx[2:0];
      hdr_byte = dest_bytes[mac_sel];
    end else if (idx < IDX_TYPE) begin
      mac_sel  = 3'(MAC_BYTES - 1) - 3'(idx - IDX_SRC_MAC);
      hdr_byte = src_bytes[mac_sel];
    end else begin
      case (idx)
        IDX_TYPE:     hdr_byte = pixel_packet_type;
        IDX_ROW_HI:   hdr_byte = 8'(item.row[COL_W-1:8]);
        IDX_ROW_LO:   hdr_byte = item.row[7:0];
        IDX_COL_HI:   hdr_byte = 8'(item.col[COL_W-1:8]);
        IDX_COL_LO:   hdr_byte = item.col[7:0];
        IDX_CNT_HI:   hdr_byte = 8'(item.cnt[CHUNK_W-1:8]);
        IDX_CNT_LO:   hdr_byte = item.cnt[7:0];
        IDX_TRAIL_HI: hdr_byte = TRAIL_HI_BYTE;
        IDX_TRAIL_LO: hdr_byte = TRAIL_LO_BYTE;
        default:      hdr_byte = '0;
      endcase
    end
  end

  // Gamma lookup: one channel per color byte, in output order
  channel_t   ch;
  logic [7:0] ram_addr;
  logic [7:0] gamma_level;

  always_comb begin
    ch = channel_sel(byte_order, 2'(idx - IDX_PIXEL));
    case (ch)
      CH_RED:   ram_addr = item.red;
      CH_GREEN: ram_addr = item.green;
      CH_BLUE:  ram_addr = item.blue;
      default:  ram_addr = item.red;
    endcase
    if (tbl_write) begin
      ram_addr = item.tbl_index;
    end
  end

  lpfp_ram #(
    .WIDTH (8),
    .DEPTH (GAMMA_DEPTH)
  ) u_gamma (
    .clk     (clk),
    .wr_en   (tbl_write),
    .rd_en   (advance && is_color),
    .addr    (ram_addr),
    .wr_data (item.tbl_value),
    .rd_data (gamma_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload of the output stage; color data is the RAM's own read register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_color <= is_color;
      out_byte  <= hdr_byte;
      out_last  <= (idx == IDX_LAST);
      out_pend  <= item.pend;
      out_fend  <= item.fend;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_color ? gamma_level : out_byte;
  assign m_axis_tlast    = out_last && out_pend;
  assign m_axis_tuser[0] = out_last && out_fend;
  assign m_axis_tuser[1] = out_last;

endmodule

>>> src/lpfp_ram.sv
// ----------------------------------------------------------------------------
// lpfp_ram
// Single-port RAM with registered read data that holds when not read.
// ----------------------------------------------------------------------------
module lpfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

>>> verif/frame_byte_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_byte_checker
// Watches the register, request and frame byte channels of the packetizer,
// works out the frame bytes of every accepted request and compares each byte
// that leaves the block, in order, against the oldest one still owed.
// ----------------------------------------------------------------------------
module frame_byte_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pixel_red, pixel_green, pixel_blue,
                                      // table_index, table_value
  input  logic        s_axis_tuser,   // req_type
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // data_byte
  input  logic        m_axis_tlast,   // packet_end
  input  logic [1:0]  m_axis_tuser,   // frame_end, run_last
  output int          mismatches,
  output int          bytes_owed
);
  import lpfp_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       pkt_end;
    logic       pic_end;
    logic       run_end;
  } frame_byte_t;

  frame_byte_t        frame_bytes_q[$];
  logic [COL_W-1:0]   width_reg;
  logic [COL_W-1:0]   height_reg;
  logic [2:0]         order_reg;
  logic [MAC_W-1:0]   dest_reg;
  logic [MAC_W-1:0]   src_reg;
  logic [7:0]         type_reg;
  logic [7:0]         gamma_lut [GAMMA_DEPTH];
  logic [COL_W-1:0]   col_pos;
  logic [COL_W-1:0]   row_pos;
  logic [CHUNK_W-1:0] owed_pixels;

  initial begin
    mismatches = 0;
    bytes_owed = 0;
  end

  function automatic void push_byte(logic [7:0] value, logic pkt_end, logic pic_end,
                                    logic run_end);
    frame_byte_t fb;
    fb = '{value, pkt_end, pic_end, run_end};
    frame_bytes_q.insert(frame_bytes_q.size(), fb);
  endfunction

  // Header when a chunk opens, then the three corrected colors of the pixel
  function automatic void pack_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    logic [COL_W-1:0] w;
    logic [COL_W-1:0] h;
    logic [COL_W-1:0] rest;
    int               cnt;
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic [7:0]       c0;
    logic [7:0]       c1;
    logic [7:0]       c2;
    logic             pkt_end;
    logic             pic_end;
    w = (width_reg == '0) ? 13'd1 : width_reg;
    h = (height_reg == '0) ? 13'd1 : height_reg;
    pkt_end = 1'b0;
    pic_end = 1'b0;
    if (owed_pixels == '0) begin
      // a lowered width or height pushes a stale position back into the panel
      if (col_pos >= w) begin
        col_pos = '0;
        row_pos = row_pos + COL_W'(1);
      end
      if (row_pos >= h) row_pos = '0;
      rest = w - col_pos;
      cnt = (rest > MAX_PIXELS) ? MAX_PIXELS : int'(rest);
      owed_pixels = cnt[CHUNK_W-1:0];
      for (int k = MAC_BYTES - 1; k >= 0; k--) push_byte(dest_reg[8*k +: 8], 1'b0, 1'b0, 1'b0);
      for (int k = MAC_BYTES - 1; k >= 0; k--) push_byte(src_reg[8*k +: 8], 1'b0, 1'b0, 1'b0);
      push_byte(type_reg, 1'b0, 1'b0, 1'b0);
      push_byte(8'(row_pos[COL_W-1:8]), 1'b0, 1'b0, 1'b0);
      push_byte(row_pos[7:0], 1'b0, 1'b0, 1'b0);
      push_byte(8'(col_pos[COL_W-1:8]), 1'b0, 1'b0, 1'b0);
      push_byte(col_pos[7:0], 1'b0, 1'b0, 1'b0);
      push_byte(cnt[15:8], 1'b0, 1'b0, 1'b0);
      push_byte(cnt[7:0], 1'b0, 1'b0, 1'b0);
      push_byte(TRAIL_HI_BYTE, 1'b0, 1'b0, 1'b0);
      push_byte(TRAIL_LO_BYTE, 1'b0, 1'b0, 1'b0);
    end

    r = gamma_lut[red];
    g = gamma_lut[green];
    b = gamma_lut[blue];
    case (order_reg)
      ORDER_BGR: begin c0 = b; c1 = g; c2 = r; end
      ORDER_GRB: begin c0 = g; c1 = r; c2 = b; end
      ORDER_GBR: begin c0 = g; c1 = b; c2 = r; end
      ORDER_RBG: begin c0 = r; c1 = b; c2 = g; end
      ORDER_BRG: begin c0 = b; c1 = r; c2 = g; end
      default:   begin c0 = r; c1 = g; c2 = b; end
    endcase

    // the chunk keeps the count from its header even if the width moved meanwhile
    owed_pixels = owed_pixels - CHUNK_W'(1);
    col_pos = col_pos + COL_W'(1);
    if (owed_pixels == '0) begin
      pkt_end = 1'b1;
      if (col_pos >= w) begin
        col_pos = '0;
        row_pos = row_pos + COL_W'(1);
        if (row_pos >= h) begin
          row_pos = '0;
          pic_end = 1'b1;
        end
      end
    end
    push_byte(c0, 1'b0, 1'b0, 1'b0);
    push_byte(c1, 1'b0, 1'b0, 1'b0);
    push_byte(c2, pkt_end, pic_end, 1'b1);
  endfunction

  always @(posedge clk) begin : monitor
    frame_byte_t got;
    frame_byte_t want;
    if (rst) begin
      width_reg   = 13'd128;
      height_reg  = 13'd64;
      order_reg   = ORDER_RGB;
      dest_reg    = '0;
      src_reg     = '0;
      type_reg    = 8'd85;
      col_pos     = '0;
      row_pos     = '0;
      owed_pixels = '0;
      foreach (gamma_lut[i]) gamma_lut[i] = '0;
      frame_bytes_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PANEL_WIDTH:  width_reg  = cfg_data[COL_W-1:0];
          REG_PANEL_HEIGHT: height_reg = cfg_data[COL_W-1:0];
          REG_BYTE_ORDER:   order_reg  = cfg_data[2:0];
          REG_DEST_MAC:     dest_reg   = cfg_data;
          REG_SRC_MAC:      src_reg    = cfg_data;
          REG_PACKET_TYPE:  type_reg   = cfg_data[7:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == REQ_TABLE) begin
          gamma_lut[s_axis_tdata[31:24]] = s_axis_tdata[39:32];
        end else begin
          pack_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]);
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]};
        if (frame_bytes_q.size() == 0) begin
          mismatches++;
          $display("%0t: expected no byte, got data %02h pkt_end %b pic_end %b last %b",
                   $time, got.value, got.pkt_end, got.pic_end, got.run_end);
        end else begin
          want = frame_bytes_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: expected data %02h pkt_end %b pic_end %b last %b, got %02h %b %b %b",
                     $time, want.value, want.pkt_end, want.pic_end, want.run_end,
                     got.value, got.pkt_end, got.pic_end, got.run_end);
          end
        end
      end
    end
    bytes_owed = frame_bytes_q.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives gamma table loads, pixel requests and register writes into the LED
// pixel frame packetizer with random idling on both streams; the byte checker
// beside the block predicts and compares every frame byte.
// ----------------------------------------------------------------------------
module testbench;
  import lpfp_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 14;
  localparam int FINAL_ITEMS    = 48;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = REG_PANEL_WIDTH;
  logic [47:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // pixel_red, pixel_green, pixel_blue,
                                    // table_index, table_value
  logic        s_axis_tuser = REQ_PIXEL;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // data_byte
  logic        m_axis_tlast;        // packet_end
  logic [1:0]  m_axis_tuser;        // frame_end, run_last
  int          mismatches;
  int          bytes_owed;

  int          tx_gap_pct = 0;
  int          rx_gap_pct = 0;
  int          rx_stall_left = 0;
  int          idle_run = 0;
  bit          rx_hold_req = 1'b0;
  logic [7:0]  loaded_idx[$];
  bit          loaded [GAMMA_DEPTH];

  led_pixel_frame_packetizer u_top (.*);

  frame_byte_checker u_checker (.*);

  always #10 clk = ~clk;

  // Byte sink: short random stalls, or one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_stall_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
      rx_stall_left = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("%0t: nothing accepted for %0d cycles", $time, idle_run);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  task automatic send_request(logic kind, logic [7:0] red, logic [7:0] green,
                              logic [7:0] blue, logic [7:0] idx, logic [7:0] level);
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {level, idx, blue, green, red};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic load_gamma(logic [7:0] idx, logic [7:0] level);
    send_request(REQ_TABLE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), idx, level);
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_idx.insert(loaded_idx.size(), idx);
    end
  endtask

  task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    send_request(REQ_PIXEL, red, green, blue, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
  endtask

  // Only gamma entries already loaded may be looked up
  function automatic logic [7:0] loaded_level();
    return loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
  endfunction

  // Leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [2:0] idx, logic [47:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic await_frame_bytes();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    wait (bytes_owed == 0);
    @(posedge clk);
  endtask

  // Table loads leave no byte behind, so give the block time to go quiet
  task automatic settle_block();
    await_frame_bytes();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_panel_setup();
    logic [47:0] mac;
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 9))
        0: write_reg(REG_PANEL_WIDTH, 48'd0);
        1: write_reg(REG_PANEL_WIDTH, 48'd1);
        9: write_reg(REG_PANEL_WIDTH, 48'($urandom_range(13, 30)));
        default: write_reg(REG_PANEL_WIDTH, 48'($urandom_range(2, 12)));
      endcase
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0: write_reg(REG_PANEL_HEIGHT, 48'd0);
        1: write_reg(REG_PANEL_HEIGHT, 48'd1);
        2: write_reg(REG_PANEL_HEIGHT, 48'($urandom_range(0, 8191)));
        default: write_reg(REG_PANEL_HEIGHT, 48'($urandom_range(2, 6)));
      endcase
    end
    if ($urandom_range(0, 1)) write_reg(REG_BYTE_ORDER, 48'($urandom_range(0, 7)));
    for (int k = 0; k < 2; k++) begin
      if ($urandom_range(0, 1)) begin
        mac = 48'({$urandom, $urandom});
        case ($urandom_range(0, 3))
          0: mac = '0;
          1: mac = '1;
          default: ;
        endcase
        write_reg((k == 0) ? REG_DEST_MAC : REG_SRC_MAC, mac);
      end
    end
    if ($urandom_range(0, 1)) write_reg(REG_PACKET_TYPE, 48'($urandom_range(0, 255)));
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int n_items;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tiny panel, field extremes, every color order
    write_reg(REG_PANEL_WIDTH, 48'd2);
    write_reg(REG_PANEL_HEIGHT, 48'd2);
    write_reg(REG_DEST_MAC, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_SRC_MAC, 48'h0123_4567_89AB);
    write_reg(REG_PACKET_TYPE, 48'hFF);
    cfg_wr_en <= 1'b0;
    load_gamma(8'h00, 8'hFF);
    load_gamma(8'hFF, 8'h00);
    load_gamma(8'h55, 8'hA5);
    load_gamma(8'hAA, 8'h5A);
    // orders 6 and 7 fall back to RGB; eight pixels close two pictures
    for (int o = 0; o < 8; o++) begin
      settle_block();
      write_reg(REG_BYTE_ORDER, 48'(o));
      cfg_wr_en <= 1'b0;
      send_pixel(8'h00, 8'hFF, 8'h55);
    end

    // zero width and height act as one: every pixel closes a picture
    settle_block();
    write_reg(REG_PANEL_WIDTH, 48'd0);
    write_reg(REG_PANEL_HEIGHT, 48'd0);
    write_reg(REG_DEST_MAC, 48'h0);
    write_reg(REG_SRC_MAC, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_PACKET_TYPE, 48'h00);
    cfg_wr_en <= 1'b0;
    send_pixel(8'hAA, 8'h55, 8'hFF);
    send_pixel(8'hFF, 8'hAA, 8'h00);

    // widen inside a chunk, then shrink so the next chunk starts out of range
    settle_block();
    write_reg(REG_PANEL_WIDTH, 48'd4);
    write_reg(REG_PANEL_HEIGHT, 48'd3);
    cfg_wr_en <= 1'b0;
    send_pixel(8'h00, 8'h55, 8'hAA);
    send_pixel(8'hFF, 8'h00, 8'h55);
    settle_block();
    write_reg(REG_PANEL_WIDTH, 48'd8);
    cfg_wr_en <= 1'b0;
    send_pixel(8'h55, 8'hAA, 8'hFF);
    send_pixel(8'hAA, 8'hFF, 8'h00);
    settle_block();
    write_reg(REG_PANEL_WIDTH, 48'd3);
    cfg_wr_en <= 1'b0;
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'h00);
    send_pixel(8'h55, 8'h55, 8'hAA);
    // row now past a lowered height at the next chunk start
    settle_block();
    write_reg(REG_PANEL_HEIGHT, 48'd1);
    cfg_wr_en <= 1'b0;
    send_pixel(8'hAA, 8'hAA, 8'h55);

    // Random phases: fresh panel setup, mixed table loads and pixels
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_block();
      pick_panel_setup();
      tx_gap_pct = (ph % 4 == 3) ? 0 : $urandom_range(5, 40);
      rx_gap_pct = (ph % 4 == 1) ? 0 : $urandom_range(5, 40);
      if (ph == 4) begin
        // hold the sink while requests keep coming so the block backs up
        rx_hold_req = 1'b1;
        tx_gap_pct = 0;
      end
      n_items = $urandom_range(24, 36);
      for (int k = 0; k < n_items; k++) begin
        if (ph == 8 && k == n_items / 2) await_frame_bytes();
        if ($urandom_range(1, 100) <= 20) begin
          load_gamma(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else begin
          send_pixel(loaded_level(), loaded_level(), loaded_level());
        end
      end
    end

    // Last stretch without idling: wide panel, chunk count clamped at the limit
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    settle_block();
    write_reg(REG_PANEL_WIDTH, 48'd4096);
    write_reg(REG_PANEL_HEIGHT, 48'd4096);
    write_reg(REG_DEST_MAC, 48'({$urandom, $urandom}));
    write_reg(REG_SRC_MAC, 48'({$urandom, $urandom}));
    cfg_wr_en <= 1'b0;
    for (int k = 0; k < FINAL_ITEMS; k++) begin
      if (k % 8 == 7) begin
        load_gamma(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        send_pixel(loaded_level(), loaded_level(), loaded_level());
      end
    end
    settle_block();

    if (mismatches == 0 && bytes_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
